FILE: rtl/core/kmr_pkg.sv
// ----------------------------------------------------------------------------
// kmr_pkg - shared types and constants for the recall@k counter
// Holds request and response payload types, sequencer states and limits.
// ----------------------------------------------------------------------------
package kmr_pkg;

   // Default number of stored ground-truth labels
   localparam int MAX_K_DEF = 16;

   // Register and field widths
   localparam int K_W      = 5;
   localparam int LABEL_W  = 32;
   localparam int COUNT_W  = 32;
   localparam int RECALL_W = 17;

   // Reset value of labels_per_query
   localparam logic [K_W-1:0] K_RESET = 5'd16;

   // Saturation limit of the counters
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Quotient bits produced by the restoring divider
   localparam int DIV_STEPS = RECALL_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

   typedef struct packed {
      logic [LABEL_W-1:0] label;
      logic               final_item;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0]  hit_count;
      logic [COUNT_W-1:0]  label_total;
      logic [RECALL_W-1:0] recall_q16;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP,
      ST_DIV,
      ST_RESP
   } state_type;

endpackage

FILE: rtl/core/knn_recall_counter.sv
// ----------------------------------------------------------------------------
// knn_recall_counter - recall@k over a stream of neighbour labels
// Stores each query's ground-truth labels, scans them for every tested
// label and on the final request divides hits by total into Q1.16.
// ----------------------------------------------------------------------------
// Flow: a ground-truth request is taken in idle; a tested request then
//   alternates read and compare over the stored labels, up to the first match.
// A final request then runs the divider and presents the result,
//   held until the response side takes it.
// One subtractor serves both label compare and division, one division step a cycle.
// Reset clears counters, query position and sets labels_per_query to 16.
module knn_recall_counter #(
   parameter int MAX_K = kmr_pkg::MAX_K_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  kmr_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output kmr_pkg::rsp_type          rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [kmr_pkg::K_W-1:0]   csr_data
);
   import kmr_pkg::*;

   localparam int CNT_W = $clog2(MAX_K + 1);
   localparam int IDX_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;
   localparam int KW    = (CNT_W > K_W) ? CNT_W : K_W;

   state_type state_ff, state_in;

   logic [K_W-1:0]       k_ff, k_in;
   logic [CNT_W-1:0]     loaded_ff, loaded_in;
   logic [CNT_W-1:0]     seen_ff, seen_in;
   logic                 phase_ff, phase_in;
   logic [COUNT_W-1:0]   hits_ff, hits_in;
   logic [COUNT_W-1:0]   total_ff, total_in;
   logic [LABEL_W-1:0]   label_ff, label_in;
   logic                 final_ff, final_in;
   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [COUNT_W:0]     rem_ff, rem_in;
   logic [RECALL_W-2:0]  quot_ff, quot_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 req_acc;
   logic                 rsp_acc;
   logic [KW-1:0]        k_eff;
   logic [KW-1:0]        k_ext;
   logic [KW-1:0]        max_ext;
   logic [CNT_W-1:0]     loaded_inc;
   logic [CNT_W-1:0]     seen_inc;
   logic                 scan_last;
   logic                 scan_done;

   // Shared subtract unit
   logic [COUNT_W+1:0]   sub_a, sub_b, sub_diff;
   logic                 sub_zero, sub_ge;

   // Label store ports
   logic                 ram_we;
   logic [IDX_W-1:0]     ram_waddr, ram_raddr;
   logic [LABEL_W-1:0]   ram_rdata;

   kmr_ram #(
      .WIDTH  (LABEL_W),
      .DEPTH  (MAX_K),
      .ADDR_W (IDX_W)
   ) u_truth_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_data.label),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_acc   = req_valid && req_ready;
   assign rsp_acc   = rsp_valid && rsp_ready;
   assign csr_ready = 1'b1;

   // Clamp k into 1..MAX_K
   assign k_ext   = KW'(k_ff);
   assign max_ext = KW'(MAX_K);
   always_comb begin
      if (k_ff == '0) begin
         k_eff = KW'(1);
      end else if (k_ext > max_ext) begin
         k_eff = max_ext;
      end else begin
         k_eff = k_ext;
      end
   end

   assign loaded_inc = loaded_ff + CNT_W'(1);
   assign seen_inc   = seen_ff + CNT_W'(1);
   assign scan_last  = (CNT_W'(idx_ff) + CNT_W'(1)) == loaded_ff;
   assign scan_done  = sub_zero || scan_last;

   // Subtract unit: label equality in compare, trial subtract in divide
   assign sub_diff = sub_a - sub_b;
   assign sub_zero = (sub_diff == '0);
   assign sub_ge   = !sub_diff[COUNT_W+1];

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (phase_ff) begin
                  state_in = ST_READ;
               end else if (req_data.final_item) begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_READ: state_in = ST_CMP;
         ST_CMP: begin
            if (scan_done) begin
               state_in = final_ff ? ST_DIV : ST_IDLE;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_DIV: begin
            if (div_cnt_ff == DIV_LAST) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_acc) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs and unit operand selection
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = loaded_ff[IDX_W-1:0];
      ram_raddr = idx_ff;
      sub_a     = {2'b00, label_ff};
      sub_b     = {2'b00, ram_rdata};
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            ram_we    = req_valid && !phase_ff;
         end
         ST_DIV: begin
            sub_a = {1'b0, rem_ff};
            sub_b = {2'b00, total_ff};
         end
         ST_RESP: rsp_valid = 1'b1;
         default: begin
         end
      endcase
   end

   // Datapath next values
   always_comb begin
      k_in       = k_ff;
      loaded_in  = loaded_ff;
      seen_in    = seen_ff;
      phase_in   = phase_ff;
      hits_in    = hits_ff;
      total_in   = total_ff;
      label_in   = label_ff;
      final_in   = final_ff;
      found_in   = found_ff;
      idx_in     = idx_ff;
      rem_in     = rem_ff;
      quot_in    = quot_ff;
      div_cnt_in = div_cnt_ff;
      rsp_in     = rsp_ff;

      // Take a register write
      if (csr_valid && csr_ready) begin
         k_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               label_in = req_data.label;
               final_in = req_data.final_item;
               found_in = 1'b0;
               idx_in   = '0;
               if (!phase_ff) begin
                  // Store a ground-truth label, switch phase at k
                  loaded_in = loaded_inc;
                  if (KW'(loaded_inc) >= k_eff) begin
                     phase_in = 1'b1;
                     seen_in  = '0;
                  end
                  if (req_data.final_item) begin
                     loaded_in = '0;
                     seen_in   = '0;
                     phase_in  = 1'b0;
                  end
               end
            end
         end
         ST_CMP: begin
            found_in = found_ff || sub_zero;
            if (scan_done) begin
               // Count the tested label, restart query at k
               if (sub_zero && (hits_ff != COUNT_MAX)) begin
                  hits_in = hits_ff + COUNT_W'(1);
               end
               if (total_ff != COUNT_MAX) begin
                  total_in = total_ff + COUNT_W'(1);
               end
               seen_in = seen_inc;
               if ((KW'(seen_inc) >= k_eff) || final_ff) begin
                  loaded_in = '0;
                  seen_in   = '0;
                  phase_in  = 1'b0;
               end
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_DIV: begin
            // One restoring step per cycle
            rem_in     = sub_ge ? {sub_diff[COUNT_W-1:0], 1'b0}
                                : {rem_ff[COUNT_W-1:0], 1'b0};
            quot_in    = {quot_ff[RECALL_W-3:0], sub_ge};
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
            if (div_cnt_ff == DIV_LAST) begin
               rsp_in.hit_count   = hits_ff;
               rsp_in.label_total = total_ff;
               rsp_in.recall_q16  = (total_ff == '0) ? '0 : {quot_ff, sub_ge};
               hits_in  = '0;
               total_in = '0;
            end
         end
         default: begin
         end
      endcase

      // Prime the divider on entry
      if ((state_in == ST_DIV) && (state_ff != ST_DIV)) begin
         rem_in     = {1'b0, hits_in};
         quot_in    = '0;
         div_cnt_in = '0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         k_ff      <= K_RESET;
         loaded_ff <= '0;
         seen_ff   <= '0;
         phase_ff  <= 1'b0;
         hits_ff   <= '0;
         total_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         k_ff      <= k_in;
         loaded_ff <= loaded_in;
         seen_ff   <= seen_in;
         phase_ff  <= phase_in;
         hits_ff   <= hits_in;
         total_ff  <= total_in;
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      label_ff   <= label_in;
      final_ff   <= final_in;
      found_ff   <= found_in;
      idx_ff     <= idx_in;
      rem_ff     <= rem_in;
      quot_ff    <= quot_in;
      div_cnt_ff <= div_cnt_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_data = rsp_ff;

   // Checks
   a_hits_le_total: assert property (@(posedge clock) disable iff (reset)
      hits_ff <= total_ff)
      else $error("hit counter exceeds total");

   a_rsp_hits_le_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.hit_count <= rsp_data.label_total))
      else $error("result hits exceed total");

   a_rsp_recall_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.recall_q16 <= RECALL_W'(65536)))
      else $error("recall above one");

   a_scan_in_store: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (CNT_W'(idx_ff) < loaded_ff))
      else $error("scan reads beyond stored labels");

endmodule

FILE: rtl/core/kmr_ram.sv
// ----------------------------------------------------------------------------
// kmr_ram - generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module kmr_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, then register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb - self-checking bench for the recall@k counter
// Streams ground-truth and tested labels query by query, keeps its own
// model of the label store and counters, and checks every response in order.
// A short directed table comes first, then random runs at several k settings.
// ----------------------------------------------------------------------------
module tb;
   import kmr_pkg::*;

   localparam int QUERY_DEPTH   = MAX_K_DEF;
   localparam int SETTLE_CYCLES = 64;
   localparam int LONG_HOLD     = 300;
   localparam int DRAIN_LIMIT   = 200000;
   localparam int RUN_LIMIT     = 4000000;
   localparam int RAND_ITEMS    = 500;
   localparam int RAND_RUNS     = 40;
   localparam int REPORT_LIMIT  = 10;

   typedef enum logic {ROW_CSR, ROW_REQ} row_kind_type;

   typedef struct {
      row_kind_type   kind;
      logic [K_W-1:0] k_val;
      req_type        req;
      bit             typed;
      rsp_type        want;
   } plan_row_type;

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           req_valid = 1'b0;
   logic           req_ready;
   req_type        req_data = '0;
   logic           rsp_valid;
   logic           rsp_ready = 1'b0;
   rsp_type        rsp_data;
   logic           csr_valid = 1'b0;
   logic           csr_ready;
   logic [K_W-1:0] csr_data = '0;

   // Model of the block
   logic [LABEL_W-1:0] truth_store [QUERY_DEPTH];
   int                 truth_count  = 0;
   int                 tested_count = 0;
   bit                 in_testing   = 1'b0;
   logic [COUNT_W-1:0] hit_acc      = '0;
   logic [COUNT_W-1:0] total_acc    = '0;
   logic [K_W-1:0]     k_reg        = K_RESET;

   rsp_type      pending_recalls [$];
   plan_row_type directed_plan [$];
   int           mismatch_count = 0;
   int           fault_count    = 0;
   bit           no_idle        = 1'b0;
   bit           rsp_hold_req   = 1'b0;

   always #5 clock = ~clock;

   knn_recall_counter uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // k in force: zero counts as one, anything above the store depth as full
   function automatic int clamp_k(input logic [K_W-1:0] raw);
      int k;
      k = raw;
      if (k < 1) k = 1;
      if (k > QUERY_DEPTH) k = QUERY_DEPTH;
      return k;
   endfunction

   function automatic void restart_query();
      truth_count  = 0;
      tested_count = 0;
      in_testing   = 1'b0;
   endfunction

   // Advance the model by one request; return 1 with the recall response on a final one
   function automatic bit predict_recall(input req_type r, output rsp_type res);
      int              k;
      bit              found;
      logic [48:0]     quo;
      k     = clamp_k(k_reg);
      found = 1'b0;
      quo   = '0;
      res   = '0;
      if (!in_testing) begin
         if (truth_count < QUERY_DEPTH) begin
            truth_store[truth_count] = r.label;
            truth_count++;
         end
         if (truth_count >= k) begin
            in_testing   = 1'b1;
            tested_count = 0;
         end
      end else begin
         for (int i = 0; i < truth_count; i++)
            if (truth_store[i] == r.label) found = 1'b1;
         if (found && hit_acc != COUNT_MAX) hit_acc++;
         if (total_acc != COUNT_MAX) total_acc++;
         tested_count++;
         if (tested_count >= k) restart_query();
      end
      if (!r.final_item) return 1'b0;
      if (total_acc != 0) quo = {hit_acc, 16'd0} / total_acc;
      if (quo > 49'd65536) quo = 49'd65536;
      res.hit_count   = hit_acc;
      res.label_total = total_acc;
      res.recall_q16  = quo[RECALL_W-1:0];
      hit_acc   = '0;
      total_acc = '0;
      restart_query();
      return 1'b1;
   endfunction

   // Half the time a small pool so that labels repeat and match, otherwise any value
   function automatic logic [LABEL_W-1:0] pick_label();
      if ($urandom_range(1) == 0) return LABEL_W'($urandom_range(7));
      return $urandom();
   endfunction

   task automatic add_csr(input logic [K_W-1:0] v);
      plan_row_type row;
      row       = '{kind: ROW_CSR, k_val: v, req: '0, typed: 1'b0, want: '0};
      directed_plan.push_back(row);
   endtask

   task automatic add_req(input logic [LABEL_W-1:0] lbl, input logic fin);
      plan_row_type row;
      row       = '{kind: ROW_REQ, k_val: '0, req: '0, typed: 1'b0, want: '0};
      row.req.label      = lbl;
      row.req.final_item = fin;
      directed_plan.push_back(row);
   endtask

   // Final request whose response is read straight off the counts
   task automatic add_final(input logic [LABEL_W-1:0] lbl, input logic [COUNT_W-1:0] h,
                            input logic [COUNT_W-1:0] t, input logic [RECALL_W-1:0] q);
      plan_row_type row;
      row       = '{kind: ROW_REQ, k_val: '0, req: '0, typed: 1'b1, want: '0};
      row.req.label        = lbl;
      row.req.final_item   = 1'b1;
      row.want.hit_count   = h;
      row.want.label_total = t;
      row.want.recall_q16  = q;
      directed_plan.push_back(row);
   endtask

   // Offer one request, hold it until taken, then record what it should produce
   task automatic send_req(input req_type r, input bit typed, input rsp_type want);
      rsp_type res;
      bit      emits;
      while (!no_idle && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      emits = predict_recall(r, res);
      if (emits) pending_recalls.push_back(typed ? want : res);
   endtask

   // Write k only once the block has drained and settled
   task automatic write_k(input logic [K_W-1:0] v);
      req_valid <= 1'b0;
      while (pending_recalls.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      k_reg = v;
      csr_valid <= 1'b0;
   endtask

   // One run of well-formed queries; a broken run drops final at a random point
   task automatic send_query_run(input int n_queries, input int k_used, input bit broken,
                                 inout int sent);
      logic [LABEL_W-1:0] truth [$];
      req_type            r;
      int                 span;
      int                 cut;
      int                 pos;
      int                 sel;
      span = n_queries * 2 * k_used;
      cut  = broken ? $urandom_range(span - 2) : span - 1;
      pos  = 0;
      for (int q = 0; q < n_queries && pos <= cut; q++) begin
         truth.delete();
         for (int j = 0; j < 2 * k_used && pos <= cut; j++) begin
            if (j < k_used) begin
               r.label = pick_label();
               truth.push_back(r.label);
            end else begin
               sel = $urandom_range(9);
               if (sel < 6) r.label = truth[$urandom_range(truth.size() - 1)];
               else r.label = pick_label();
            end
            r.final_item = (pos == cut);
            send_req(r, 1'b0, '0);
            pos++;
            sent++;
         end
      end
   endtask

   // Response side: check in order, idle at random, hold off on request
   initial begin : rsp_sink
      rsp_type want;
      int      hold_left;
      hold_left = 0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            if (pending_recalls.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("unexpected response: hits %0d total %0d recall %0d",
                           rsp_data.hit_count, rsp_data.label_total, rsp_data.recall_q16);
            end else begin
               want = pending_recalls.pop_front();
               if (rsp_data.hit_count !== want.hit_count ||
                   rsp_data.label_total !== want.label_total ||
                   rsp_data.recall_q16 !== want.recall_q16) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display("mismatch: expected hits %0d total %0d recall %0d, got %0d %0d %0d",
                              want.hit_count, want.label_total, want.recall_q16,
                              rsp_data.hit_count, rsp_data.label_total, rsp_data.recall_q16);
               end
            end
         end
         if (rsp_hold_req) begin
            hold_left    = LONG_HOLD;
            rsp_hold_req = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= no_idle || ($urandom_range(99) >= 34);
         end
      end
   end

   // Stop a hung run
   initial begin : watchdog
      #(RUN_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin : stimulus
      plan_row_type       row;
      logic [K_W-1:0]     k_new;
      logic [K_W-1:0]     k_extremes [4];
      int                 k_used;
      int                 rand_items;
      int                 rand_runs;
      int                 phase_idx;
      int                 wait_cycles;
      int                 pressure_items;

      k_extremes = '{5'd16, 5'd0, 5'd31, 5'd1};
      rand_items = 0;
      rand_runs  = 0;
      phase_idx  = 0;

      // Directed table: reset k, smallest k, k of zero, repeats
      add_final(32'd0, 32'd0, 32'd0, 17'd0);
      add_csr(5'd1);
      add_req(32'hFFFF_FFFF, 1'b0);
      add_final(32'hFFFF_FFFF, 32'd1, 32'd1, 17'd65536);
      add_req(32'd0, 1'b0);
      add_final(32'd5, 32'd0, 32'd1, 17'd0);
      add_csr(5'd0);
      add_req(32'd7, 1'b0);
      add_req(32'd7, 1'b0);
      add_req(32'd8, 1'b0);
      add_final(32'd9, 32'd1, 32'd2, 17'd32768);
      add_csr(5'd3);
      add_req(32'd5, 1'b0);
      add_req(32'd5, 1'b0);
      add_req(32'd6, 1'b0);
      add_req(32'd5, 1'b0);
      add_req(32'd5, 1'b0);
      add_final(32'd7, 32'd2, 32'd3, 17'd43690);
      // final while still loading ground truth
      add_req(32'd1, 1'b0);
      add_final(32'd2, 32'd0, 32'd0, 17'd0);
      add_csr(5'd2);
      // final part-way through the tested labels
      add_req(32'd3, 1'b0);
      add_req(32'd4, 1'b0);
      add_final(32'd3, 32'd1, 32'd1, 17'd65536);
      // final on the first label of the next query
      add_req(32'hAAAA_AAAA, 1'b0);
      add_req(32'h5555_5555, 1'b0);
      add_req(32'h5555_5555, 1'b0);
      add_req(32'd0, 1'b0);
      add_final(32'd9, 32'd1, 32'd2, 17'd32768);

      // Hold reset, then release
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table
      foreach (directed_plan[i]) begin
         row = directed_plan[i];
         if (row.kind == ROW_CSR) write_k(row.k_val);
         else send_req(row.req, row.typed, row.want);
      end

      // Random phases: the extremes of k first, then mostly small k
      while (rand_items < RAND_ITEMS || rand_runs < RAND_RUNS) begin
         if (phase_idx < 4) k_new = k_extremes[phase_idx];
         else if ($urandom_range(7) == 0) k_new = K_W'($urandom_range(31));
         else k_new = K_W'($urandom_range(1, 5));
         write_k(k_new);
         k_used  = clamp_k(k_new);
         no_idle = (phase_idx >= 6 && phase_idx < 9);
         if (phase_idx == 5) begin
            // Stall the response side while short runs keep coming
            write_k(5'd1);
            rsp_hold_req   = 1'b1;
            pressure_items = 0;
            repeat (24) send_query_run(1, 1, 1'b0, pressure_items);
            rand_items += pressure_items;
            rand_runs  += 24;
         end else begin
            repeat ($urandom_range(1, 3)) begin
               send_query_run(k_used > 8 ? 1 : $urandom_range(1, 3), k_used,
                              $urandom_range(9) == 0, rand_items);
               rand_runs++;
               // now and then let every response come home before going on
               if ($urandom_range(5) == 0) begin
                  req_valid <= 1'b0;
                  do @(posedge clock); while (pending_recalls.size() != 0);
               end
            end
         end
         phase_idx++;
      end
      no_idle = 1'b0;

      // Drain and settle
      req_valid   <= 1'b0;
      wait_cycles = 0;
      while (pending_recalls.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_recalls.size() != 0) begin
         fault_count++;
         $display("%0d expected responses never arrived", pending_recalls.size());
      end
      fault_count += mismatch_count;
      if (fault_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/core/kmr_pkg.sv
rtl/core/kmr_ram.sv
rtl/core/knn_recall_counter.sv
tb/tb.sv
